// ===== rtl/mos_pkg.sv =====
// Package for the median_of_sample_set block: sizes, item structs, cell opcodes.
// No dependencies; imported by mos_cell and median_of_sample_set.
package mos_pkg;

  localparam int MaxSamples  = 256;
  localparam int SampleWidth = 16;
  localparam int MedianWidth = SampleWidth + 1;
  localparam int CountWidth  = $clog2(MaxSamples + 1);
  localparam int SeekWidth   = $clog2(MaxSamples / 2 + 1);

  typedef struct packed {
    logic signed [SampleWidth-1:0] sample;
    logic                          last_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [MedianWidth-1:0] median_doubled;
    logic [CountWidth-1:0]         sample_count;
    logic                          overflowed;
  } out_item_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_op_e;

endpackage

// ===== rtl/mos_cell.sv =====
// One cell of the sorted chain: holds one sample and compares it to the incoming one.
// Depends on mos_pkg.
module mos_cell import mos_pkg::*; (
  input  logic                          clk_i,
  input  cell_op_e                      op_i,
  input  logic signed [SampleWidth-1:0] sample_i,
  input  logic                          occupied_i,
  input  logic signed [SampleWidth-1:0] left_val_i,
  input  logic                          left_gt_i,
  input  logic signed [SampleWidth-1:0] right_val_i,
  output logic signed [SampleWidth-1:0] val_o,
  output logic                          gt_o
);

  logic signed [SampleWidth-1:0] val_q, val_d;

  // empty cells act as +infinity
  assign gt_o  = !occupied_i || (val_q > sample_i);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    case (op_i)
      CELL_INSERT: begin
        if (left_gt_i) begin
          val_d = left_val_i;
        end else if (gt_o) begin
          val_d = sample_i;
        end
      end
      CELL_SHIFT: val_d = right_val_i;
      default:    val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// ===== rtl/median_of_sample_set.sv =====
// Top level of median_of_sample_set: insertion chain of mos_cell plus control.
// Depends on mos_pkg and mos_cell.
//
//   channel | signals                     | payload
//   in      | in_valid_i / in_ready_o     | in_item_t  (sample, last_sample)
//   out     | out_valid_o / out_ready_i   | out_item_t (median_doubled, sample_count, overflowed)
//
// A sample without last_sample is accepted while idle; the chain inserts it in place or, when
// full, drops it and flags overflowed. The closing sample is handled alike, then the chain
// shifts toward cell 0 once per cycle until the lower middle element sits in cell 0, and the
// result register is loaded once it is free. Input is held off meanwhile.
// A result waits in the output register; the next set may start before it is taken.
// Reset empties the chain through the fill count; cell contents are not cleared.
module median_of_sample_set import mos_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SEEK = 1'b1;

  logic                  state_q, state_d;
  logic [CountWidth-1:0] count_q, count_d;
  logic                  drop_q, drop_d;
  logic [SeekWidth-1:0]  seek_q, seek_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_item_q, out_item_d;

  logic                  accept, full, emit;
  logic [CountWidth-1:0] count_ins;
  logic [SeekWidth-1:0]  seek_init;
  cell_op_e              op;

  logic signed [SampleWidth-1:0] val [MaxSamples];
  logic                          gt  [MaxSamples];
  logic signed [MedianWidth-1:0] med_a, med_b;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CountWidth'(MaxSamples));
  assign count_ins  = full ? count_q : count_q + CountWidth'(1);
  assign seek_init  = count_ins[0] ? SeekWidth'(count_ins[CountWidth-1:1])
                                   : SeekWidth'(count_ins[CountWidth-1:1]) - SeekWidth'(1);
  assign emit       = (state_q == ST_SEEK) && (seek_q == '0)
                      && (!out_valid_q || out_ready_i);

  always_comb begin
    if (accept && !full) begin
      op = CELL_INSERT;
    end else if ((state_q == ST_SEEK) && (seek_q != '0)) begin
      op = CELL_SHIFT;
    end else begin
      op = CELL_HOLD;
    end
  end

  for (genvar i = 0; i < MaxSamples; i++) begin : g_cell
    logic signed [SampleWidth-1:0] left_val, right_val;
    logic                          left_gt, occupied;

    assign occupied = (CountWidth'(i) < count_q);
    if (i == 0) begin : g_first
      assign left_val = val[i];
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_val = val[i-1];
      assign left_gt  = gt[i-1];
    end
    if (i == MaxSamples - 1) begin : g_last
      assign right_val = val[i];
    end else begin : g_inner
      assign right_val = val[i+1];
    end

    mos_cell u_cell (
      .clk_i       (clk_i),
      .op_i        (op),
      .sample_i    (in_item_i.sample),
      .occupied_i  (occupied),
      .left_val_i  (left_val),
      .left_gt_i   (left_gt),
      .right_val_i (right_val),
      .val_o       (val[i]),
      .gt_o        (gt[i])
    );
  end

  assign med_a = MedianWidth'(val[0]);
  assign med_b = MedianWidth'(val[1]);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    drop_d      = drop_q;
    seek_d      = seek_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_item_d  = out_item_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          count_d = count_ins;
          drop_d  = drop_q | full;
          if (in_item_i.last_sample) begin
            seek_d  = seek_init;
            state_d = ST_SEEK;
          end
        end
      end
      ST_SEEK: begin
        if (seek_q != '0) begin
          seek_d = seek_q - SeekWidth'(1);
        end else if (emit) begin
          out_valid_d                = 1'b1;
          out_item_d.median_doubled  = count_q[0] ? (med_a + med_a) : (med_a + med_b);
          out_item_d.sample_count    = count_q;
          out_item_d.overflowed      = drop_q;
          count_d                    = '0;
          drop_d                     = 1'b0;
          state_d                    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      drop_q      <= 1'b0;
      seek_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      drop_q      <= drop_d;
      seek_q      <= seek_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
